// ----- rtl/pip_pkg.sv -----
// Shared constants and types for the point-in-polygon test block.
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int TOL_W        = 15;
  localparam int FUNC_W       = 2;
  localparam int MIN_VALID    = 3;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_W + 1;         // coordinate difference
  localparam int MUL_W  = DIFF_W + 1;          // multiplier operand, signed
  localparam int LO_W   = DIFF_W;              // low slice for split products
  localparam int SQ_W   = 2 * DIFF_W + 1;      // sums of two products
  localparam int ACR_W  = 2 * COORD_W + 1;     // magnitude of the cross product
  localparam int TOL2_W = 2 * TOL_W;
  localparam int WIDE_W = 2 * ACR_W;           // squared cross product and its bound
  localparam int ACC_W  = WIDE_W + 2;
  localparam int SH_W   = $clog2(2 * LO_W + 1);

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic            clr;
    logic            sub;
    logic [SH_W-1:0] sh;
  } mac_ctrl_t;

endpackage

// ----- rtl/pip_mac.sv -----
// Shared signed multiply-accumulate unit with a shifted, signed addend.
`timescale 1ns / 1ps

module pip_mac (
  input  logic                                  clk,
  input  logic signed [pip_pkg::MUL_W-1:0]      mul_a,
  input  logic signed [pip_pkg::MUL_W-1:0]      mul_b,
  input  pip_pkg::mac_ctrl_t                    ctl,
  output logic signed [pip_pkg::ACC_W-1:0]      acc_nxt
);
  import pip_pkg::*;

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc_r;

  assign prod = mul_a * mul_b;
  assign term = ACC_W'(prod) <<< ctl.sh;
  assign base = ctl.clr ? '0 : acc_r;
  assign acc_nxt = ctl.sub ? (base - term) : (base + term);

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

// ----- rtl/point_in_polygon_test.sv -----
// Top level of the point-in-polygon test: vertex table, sequencer and result register.
`timescale 1ns / 1ps

// Words on the input channel clear the vertex table, append a vertex or query
// a point; only a query returns a word. A query of a polygon with n >= 3
// vertices runs a boundary pass over every edge and then a crossing pass (the
// crossing pass is skipped on a boundary hit, and the boundary pass stops at
// the first hit); with fewer than three vertices it goes straight to the
// result. Both passes run on the single 18x18 multiply-accumulate unit that
// every product goes through, one partial product per cycle. The input is not
// ready while a query runs; a finished result waits in the output register
// while the next word is taken.

module point_in_polygon_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pip_pkg::TOL_W-1:0]           cfg_edge_tolerance,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pip_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [pip_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0]  in_coord_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_inside_res,
  output logic                                out_on_edge,
  output logic                                out_polygon_valid,
  output logic                                out_overflowed
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TOL, S_FETCH, S_BND, S_XFETCH, S_XING, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    B_LEN0, B_LEN1, B_PRJ0, B_PRJ1, B_DW0, B_DW1, B_DU0, B_DU1,
    B_CR0, B_CR1, B_CQ0, B_CQ1, B_CQ2, B_RH0, B_RH1, B_RH2, B_RH3, B_DEC
  } step_t;

  state_t state_r;
  step_t  step_r;
  logic   xstep_r;

  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [TOL_W-1:0]  tol_r;
  logic [IDX_W-1:0]  i_r;

  logic signed [COORD_W-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

  logic [TOL2_W-1:0]       tol2_r;
  logic signed [SQ_W-1:0]  len2_r, proj_r, dw_r, du_r, lhs_r;
  logic [ACR_W-1:0]        acr_r;
  logic [WIDE_W-1:0]       cr2_r, rhs_r;

  logic res_inside_r, res_edge_r, res_pvalid_r;
  logic out_valid_r, out_inside_r, out_edge_r, out_pvalid_r, out_ovf_r;

  logic [IDX_W-1:0] last_idx, j_idx;
  logic             is_last, wr_en, rd_en, accept;

  logic signed [DIFF_W-1:0] dx, dy, wx, wy, ux, uy;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  mac_ctrl_t                ctl;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [SQ_W-1:0]   acc_sq, acc_abs;
  logic signed [SQ_W-1:0]   tol2_sq;
  logic                     near, straddle, left;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (in_func == FUNC_APPEND) && (cnt_r < CNT_W'(MAX_VERTICES));
  assign rd_en     = (state_r == S_FETCH) || (state_r == S_XFETCH);

  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign j_idx    = (i_r == '0) ? last_idx : IDX_W'(i_r - IDX_W'(1));
  assign is_last  = (i_r == last_idx);

  // Vertex j is the edge start (a), vertex i its end (b).
  assign dx = DIFF_W'(bx_r) - DIFF_W'(ax_r);
  assign dy = DIFF_W'(by_r) - DIFF_W'(ay_r);
  assign wx = DIFF_W'(px_r) - DIFF_W'(ax_r);
  assign wy = DIFF_W'(py_r) - DIFF_W'(ay_r);
  assign ux = DIFF_W'(px_r) - DIFF_W'(bx_r);
  assign uy = DIFF_W'(py_r) - DIFF_W'(by_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[cnt_r[IDX_W-1:0]] <= in_coord_x;
      mem_y[cnt_r[IDX_W-1:0]] <= in_coord_y;
    end
    if (rd_en) begin
      ax_r <= mem_x[j_idx];
      ay_r <= mem_y[j_idx];
      bx_r <= mem_x[i_r];
      by_r <= mem_y[i_r];
    end
  end

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ctl   = '{clr: 1'b1, sub: 1'b0, sh: '0};
    unique case (state_r)
      S_TOL: begin
        mul_a = MUL_W'({1'b0, tol_r});
        mul_b = MUL_W'({1'b0, tol_r});
      end
      S_BND: begin
        unique case (step_r)
          B_LEN0: begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
          B_LEN1: begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); ctl.clr = 1'b0; end
          B_PRJ0: begin mul_a = MUL_W'(wx); mul_b = MUL_W'(dx); end
          B_PRJ1: begin mul_a = MUL_W'(wy); mul_b = MUL_W'(dy); ctl.clr = 1'b0; end
          B_DW0:  begin mul_a = MUL_W'(wx); mul_b = MUL_W'(wx); end
          B_DW1:  begin mul_a = MUL_W'(wy); mul_b = MUL_W'(wy); ctl.clr = 1'b0; end
          B_DU0:  begin mul_a = MUL_W'(ux); mul_b = MUL_W'(ux); end
          B_DU1:  begin mul_a = MUL_W'(uy); mul_b = MUL_W'(uy); ctl.clr = 1'b0; end
          B_CR0:  begin mul_a = MUL_W'(dx); mul_b = MUL_W'(wy); end
          B_CR1: begin
            mul_a = MUL_W'(dy);
            mul_b = MUL_W'(wx);
            ctl.clr = 1'b0;
            ctl.sub = 1'b1;
          end
          // The squared cross product is built from a low and a high slice.
          B_CQ0: begin
            mul_a = MUL_W'({1'b0, acr_r[LO_W-1:0]});
            mul_b = MUL_W'({1'b0, acr_r[LO_W-1:0]});
          end
          B_CQ1: begin
            mul_a = MUL_W'({1'b0, acr_r[ACR_W-1:LO_W]});
            mul_b = MUL_W'({1'b0, acr_r[LO_W-1:0]});
            ctl.clr = 1'b0;
            ctl.sh  = SH_W'(LO_W + 1);
          end
          B_CQ2: begin
            mul_a = MUL_W'({1'b0, acr_r[ACR_W-1:LO_W]});
            mul_b = MUL_W'({1'b0, acr_r[ACR_W-1:LO_W]});
            ctl.clr = 1'b0;
            ctl.sh  = SH_W'(2 * LO_W);
          end
          // Squared tolerance times squared edge length, four partial products.
          B_RH0: begin
            mul_a = MUL_W'({1'b0, tol2_r[TOL_W-1:0]});
            mul_b = MUL_W'({1'b0, len2_r[LO_W-1:0]});
          end
          B_RH1: begin
            mul_a = MUL_W'({1'b0, tol2_r[TOL_W-1:0]});
            mul_b = MUL_W'({1'b0, len2_r[2*LO_W-1:LO_W]});
            ctl.clr = 1'b0;
            ctl.sh  = SH_W'(LO_W);
          end
          B_RH2: begin
            mul_a = MUL_W'({1'b0, tol2_r[TOL2_W-1:TOL_W]});
            mul_b = MUL_W'({1'b0, len2_r[LO_W-1:0]});
            ctl.clr = 1'b0;
            ctl.sh  = SH_W'(TOL_W);
          end
          B_RH3: begin
            mul_a = MUL_W'({1'b0, tol2_r[TOL2_W-1:TOL_W]});
            mul_b = MUL_W'({1'b0, len2_r[2*LO_W-1:LO_W]});
            ctl.clr = 1'b0;
            ctl.sh  = SH_W'(LO_W + TOL_W);
          end
          default: begin end
        endcase
      end
      S_XING: begin
        if (!xstep_r) begin
          mul_a = MUL_W'(wx);
          mul_b = MUL_W'(dy);
        end else begin
          mul_a = MUL_W'(wy);
          mul_b = MUL_W'(dx);
        end
      end
      default: begin end
    endcase
  end

  pip_mac u_mac (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .ctl     (ctl),
    .acc_nxt (acc_nxt)
  );

  assign acc_sq  = acc_nxt[SQ_W-1:0];
  assign acc_abs = (acc_sq < 0) ? -acc_sq : acc_sq;
  assign tol2_sq = SQ_W'(tol2_r);

  // Nearest point of the segment is an endpoint or the foot of the normal.
  always_comb begin
    if (proj_r <= 0) begin
      near = (dw_r <= tol2_sq);
    end else if (proj_r >= len2_r) begin
      near = (du_r <= tol2_sq);
    end else begin
      near = (cr2_r <= rhs_r);
    end
  end

  assign straddle = (by_r > py_r) != (ay_r > py_r);
  assign left     = (dy > 0) ? (lhs_r < acc_sq) : (lhs_r > acc_sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= B_LEN0;
      xstep_r     <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      tol_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_edge_tolerance;
      end
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            priority case (in_func)
              FUNC_CLEAR: begin
                cnt_r <= '0;
                ovf_r <= 1'b0;
              end
              FUNC_APPEND: begin
                if (cnt_r < CNT_W'(MAX_VERTICES)) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              FUNC_QUERY: begin
                px_r         <= in_coord_x;
                py_r         <= in_coord_y;
                res_inside_r <= 1'b0;
                res_edge_r   <= 1'b0;
                res_pvalid_r <= (cnt_r >= CNT_W'(MIN_VALID));
                i_r          <= '0;
                state_r      <= (cnt_r >= CNT_W'(MIN_VALID)) ? S_TOL : S_DONE;
              end
              default: begin end
            endcase
          end
        end
        S_TOL: begin
          tol2_r  <= acc_nxt[TOL2_W-1:0];
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          step_r  <= B_LEN0;
          state_r <= S_BND;
        end
        S_BND: begin
          unique case (step_r)
            B_LEN1: len2_r <= acc_sq;
            B_PRJ1: proj_r <= acc_sq;
            B_DW1:  dw_r   <= acc_sq;
            B_DU1:  du_r   <= acc_sq;
            B_CR1:  acr_r  <= acc_abs[ACR_W-1:0];
            B_CQ2:  cr2_r  <= acc_nxt[WIDE_W-1:0];
            B_RH3:  rhs_r  <= acc_nxt[WIDE_W-1:0];
            default: begin end
          endcase
          if (step_r == B_DEC) begin
            if (near) begin
              res_inside_r <= 1'b1;
              res_edge_r   <= 1'b1;
              state_r      <= S_DONE;
            end else if (is_last) begin
              i_r     <= '0;
              state_r <= S_XFETCH;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= S_FETCH;
            end
          end else begin
            step_r <= step_t'(step_r + 5'd1);
          end
        end
        S_XFETCH: begin
          xstep_r <= 1'b0;
          state_r <= S_XING;
        end
        S_XING: begin
          if (!xstep_r) begin
            lhs_r   <= acc_sq;
            xstep_r <= 1'b1;
          end else begin
            if (straddle && left) begin
              res_inside_r <= !res_inside_r;
            end
            if (is_last) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= S_XFETCH;
            end
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_inside_r <= res_inside_r;
            out_edge_r   <= res_edge_r;
            out_pvalid_r <= res_pvalid_r;
            out_ovf_r    <= ovf_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_inside_res    = out_inside_r;
  assign out_on_edge       = out_edge_r;
  assign out_polygon_valid = out_pvalid_r;
  assign out_overflowed    = out_ovf_r;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the point-in-polygon test block.
`timescale 1ns / 1ps

module testbench;
  import pip_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic inside_res;
    logic on_edge;
    logic polygon_valid;
    logic overflowed;
  } verdict_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    int                x;
    int                y;
    bit                fixed;
    verdict_t          verdict;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_edge_tolerance = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = FUNC_CLEAR;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res, out_on_edge, out_polygon_valid, out_overflowed;

  point_in_polygon_test i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_edge_tolerance (cfg_edge_tolerance),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_coord_x         (in_coord_x),
    .in_coord_y         (in_coord_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_inside_res     (out_inside_res),
    .out_on_edge        (out_on_edge),
    .out_polygon_valid  (out_polygon_valid),
    .out_overflowed     (out_overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's state.
  longint   poly_x [MAX_VERTICES];
  longint   poly_y [MAX_VERTICES];
  int       poly_count = 0;
  bit       poly_overflow = 0;
  longint   tolerance = 0;
  verdict_t pending_verdicts [$];
  int       errors = 0;
  int       cycles = 0;
  int       gap_next = 0;
  bit       quiet = 0;
  int       items = 0;

  function automatic bit near_edge(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by);
    logic [127:0] tol2, lhs, rhs;
    longint dx, dy, wx, wy, len2, proj, cr;
    tol2 = tolerance * tolerance;
    dx = bx - ax; dy = by - ay;
    wx = px - ax; wy = py - ay;
    len2 = dx * dx + dy * dy;
    proj = wx * dx + wy * dy;
    if (proj <= 0) return 128'(wx * wx + wy * wy) <= tol2;
    if (proj >= len2) return 128'((px - bx) * (px - bx) + (py - by) * (py - by)) <= tol2;
    cr = dx * wy - dy * wx;
    if (cr < 0) cr = -cr;
    lhs = 128'(cr) * 128'(cr);
    rhs = tol2 * 128'(len2);
    return lhs <= rhs;
  endfunction

  function automatic verdict_t classify_point(longint px, longint py);
    verdict_t v;
    int j;
    longint dy, lhs, rhs;
    bit left;
    v = '0;
    v.overflowed = poly_overflow;
    if (poly_count < MIN_VALID) return v;
    v.polygon_valid = 1'b1;
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      if (!v.on_edge && near_edge(px, py, poly_x[j], poly_y[j], poly_x[i], poly_y[i]))
        v.on_edge = 1'b1;
      j = i;
    end
    if (v.on_edge) begin
      v.inside_res = 1'b1;
      return v;
    end
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        dy = poly_y[i] - poly_y[j];
        lhs = (px - poly_x[j]) * dy;
        rhs = (py - poly_y[j]) * (poly_x[i] - poly_x[j]);
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) v.inside_res = ~v.inside_res;
      end
      j = i;
    end
    return v;
  endfunction

  // Drives one word, updates the shadow state once it is taken.
  task automatic send_word(logic [FUNC_W-1:0] func, int x, int y, bit fixed = 0,
                           verdict_t fixed_verdict = '0);
    bit ready_seen;
    verdict_t v;
    repeat (gap_next) @(posedge clk);
    in_func    <= func;
    in_coord_x <= x[COORD_W-1:0];
    in_coord_y <= y[COORD_W-1:0];
    in_valid   <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    items++;
    case (func)
      FUNC_CLEAR: begin
        poly_count = 0;
        poly_overflow = 0;
      end
      FUNC_APPEND: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = longint'($signed(x[COORD_W-1:0]));
          poly_y[poly_count] = longint'($signed(y[COORD_W-1:0]));
          poly_count++;
        end else begin
          poly_overflow = 1;
        end
      end
      FUNC_QUERY: begin
        v = classify_point(longint'($signed(x[COORD_W-1:0])),
                           longint'($signed(y[COORD_W-1:0])));
        if (fixed && v != fixed_verdict) begin
          $display("%0t: table entry disagrees with prediction: table %b predicted %b",
                   $time, fixed_verdict, v);
          errors++;
        end
        pending_verdicts.insert(pending_verdicts.size(), fixed ? fixed_verdict : v);
      end
      default: ;
    endcase
    gap_next = quiet ? 0 : $urandom_range(0, 9);
    if (gap_next > 0) in_valid <= 1'b0;
  endtask

  // A nonzero gap means the last word already dropped valid.
  task automatic release_input();
    if (gap_next == 0) in_valid <= 1'b0;
    gap_next = 0;
  endtask

  task automatic drain();
    release_input();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_tolerance(int value);
    bit ready_seen;
    drain();
    cfg_edge_tolerance <= value[TOL_W-1:0];
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    tolerance = value & 32'h7fff;
  endtask

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int random_coord(int center, int spread);
    if ($urandom_range(0, 7) == 0) return $signed(16'($urandom));
    return clamp_coord(center + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Builds a polygon and queries points around it.
  task automatic polygon_sequence();
    int n, spread, k, a, b;
    int qx, qy;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    spread = ($urandom_range(0, 3) == 0) ? 30000 : 2000;
    send_word(FUNC_CLEAR, $signed(16'($urandom)), $signed(16'($urandom)));
    for (int i = 0; i < n; i++)
      send_word(FUNC_APPEND, random_coord(0, spread), random_coord(0, spread));
    k = $urandom_range(3, 8);
    for (int i = 0; i < k; i++) begin
      a = (poly_count > 0) ? $urandom_range(0, poly_count - 1) : 0;
      b = (poly_count > 0) ? (a + 1) % poly_count : 0;
      case ($urandom_range(0, 5))
        0: begin
          qx = random_coord(int'(poly_x[a]), 3);
          qy = random_coord(int'(poly_y[a]), 3);
        end
        1: begin
          qx = clamp_coord(int'((poly_x[a] + poly_x[b]) / 2) + $urandom_range(0, 6) - 3);
          qy = clamp_coord(int'((poly_y[a] + poly_y[b]) / 2) + $urandom_range(0, 6) - 3);
        end
        2: begin
          qx = $signed(16'($urandom));
          qy = $signed(16'($urandom));
        end
        default: begin
          qx = random_coord(0, spread);
          qy = random_coord(0, spread);
        end
      endcase
      if (poly_count == 0) begin
        qx = $signed(16'($urandom));
        qy = $signed(16'($urandom));
      end
      send_word(FUNC_QUERY, qx, qy);
      if ($urandom_range(0, 9) == 0)
        send_word($urandom_range(0, 3) == 0 ? FUNC_UNUSED : FUNC_APPEND,
                  $signed(16'($urandom)), $signed(16'($urandom)));
    end
  endtask

  // Result side: sampled mid-cycle, so the handshake seen here is the one taken
  // at the next rising edge.
  bit result_taken = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    verdict_t got, want;
    result_taken = rst_n && out_valid && out_ready;
    if (result_taken) begin
      got = {out_inside_res, out_on_edge, out_polygon_valid, out_overflowed};
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word %b", $time, got);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %b actual %b", $time, want.inside_res,
                   got.inside_res);
          errors++;
        end
        if (got.on_edge !== want.on_edge) begin
          $display("%0t: on_edge expected %b actual %b", $time, want.on_edge, got.on_edge);
          errors++;
        end
        if (got.polygon_valid !== want.polygon_valid) begin
          $display("%0t: polygon_valid expected %b actual %b", $time, want.polygon_valid,
                   got.polygon_valid);
          errors++;
        end
        if (got.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %b actual %b", $time, want.overflowed,
                   got.overflowed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (result_taken) stall_left <= quiet ? 0 : $urandom_range(0, 9);
    else if (stall_left > 0) stall_left <= stall_left - 1;
    out_ready <= rst_n && !result_taken && stall_left == 0;
  end

  vector_t vectors [$];

  initial begin
    vectors = '{
      '{FUNC_QUERY, 0, 0, 1, 4'b0000},
      '{FUNC_APPEND, -32768, -32768, 0, 4'b0000},
      '{FUNC_APPEND, 32767, -32768, 0, 4'b0000},
      '{FUNC_QUERY, 0, 0, 1, 4'b0000},
      '{FUNC_APPEND, 32767, 32767, 0, 4'b0000},
      '{FUNC_QUERY, 32767, 32767, 0, 4'b0000},
      '{FUNC_QUERY, 0, 0, 0, 4'b0000},
      '{FUNC_QUERY, 20000, -10000, 0, 4'b0000},
      '{FUNC_QUERY, -32768, 32767, 0, 4'b0000},
      '{FUNC_UNUSED, 12345, -12345, 0, 4'b0000},
      // A repeated vertex leaves a zero-length edge.
      '{FUNC_APPEND, -32768, -32768, 0, 4'b0000},
      '{FUNC_QUERY, -32768, -32767, 0, 4'b0000},
      '{FUNC_CLEAR, 0, 0, 0, 4'b0000},
      '{FUNC_QUERY, 0, 0, 1, 4'b0000},
      '{FUNC_APPEND, 0, 0, 0, 4'b0000},
      '{FUNC_APPEND, 100, 0, 0, 4'b0000},
      '{FUNC_APPEND, 100, 100, 0, 4'b0000},
      '{FUNC_APPEND, 0, 100, 0, 4'b0000},
      '{FUNC_QUERY, 50, 0, 0, 4'b0000},
      '{FUNC_QUERY, 50, 50, 0, 4'b0000},
      '{FUNC_QUERY, 150, 100, 0, 4'b0000},
      '{FUNC_QUERY, -1, 100, 0, 4'b0000}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_tolerance(0);
    foreach (vectors[i])
      send_word(vectors[i].func, vectors[i].x, vectors[i].y, vectors[i].fixed,
                vectors[i].verdict);
    write_tolerance(32767);
    send_word(FUNC_QUERY, 32767, -32768);
    send_word(FUNC_QUERY, -32768, 32767);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_tolerance(0);
        1: write_tolerance(32767);
        2: write_tolerance($urandom_range(1, 20));
        3: write_tolerance($urandom_range(0, 32767));
        4: write_tolerance(1);
        default: write_tolerance($urandom_range(100, 3000));
      endcase
      quiet = (phase == 2);
      while (items < 100 * (phase + 1) + 20) begin
        polygon_sequence();
        if ($urandom_range(0, 5) == 0) drain();
      end
    end
    quiet = 0;

    drain();
    begin : final_wait
      int guard;
      guard = 0;
      while (pending_verdicts.size() != 0 && guard < 20000) begin
        @(posedge clk);
        guard++;
      end
      repeat (50) @(posedge clk);
    end
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
